/* design/ifht_pkg.sv */
// shared types, constants and helpers for the ip fragment hole tracker
`default_nettype none
package ifht_pkg;
   localparam int NUM_SLOTS = 8;
   localparam int MAX_FRAGS = 16;
   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int IDX_W = $clog2(MAX_FRAGS);
   localparam int CNT_W = $clog2(MAX_FRAGS + 1);
   localparam int ADDR_W = SLOT_W + IDX_W;
   localparam int DEPTH = NUM_SLOTS * MAX_FRAGS;
   localparam logic [2:0] ALIGN_MASK = 3'd7;

   typedef enum logic [2:0] {
      ST_ACCEPT   = 3'd0,
      ST_COMPLETE = 3'd1,
      ST_REJECT   = 3'd2,
      ST_INVALID  = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef struct packed {
      logic [15:0] start;
      logic [15:0] length;
   } ivl_type;

   typedef enum logic [3:0] {
      S_IDLE, S_EXPIRE, S_OPEN, S_CHECK, S_SCAN_RD, S_SCAN_CHK, S_EVAL,
      S_SHIFT_RD, S_SHIFT_WR, S_INSERT, S_FINISH, S_RESP
   } state_type;

   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction
endpackage
`default_nettype wire

/* design/ifht_ivl_ram.sv */
// interval store, one write and one registered read port
`default_nettype none
module ifht_ivl_ram (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [ifht_pkg::ADDR_W-1:0] wr_addr,
   input  wire ifht_pkg::ivl_type      wr_data,
   input  wire logic                   rd_en,
   input  wire logic [ifht_pkg::ADDR_W-1:0] rd_addr,
   output ifht_pkg::ivl_type           rd_data
);
   import ifht_pkg::*;

   ivl_type mem [DEPTH];
   ivl_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

/* design/ip_fragment_hole_tracker.sv */
// top level: context table, sequencer and counters of the hole tracker
// Each request first scans the deadlines of all slots, then reads the stored
// intervals of its slot up to the insertion point, then moves the later ones up
// to make room for the new one. busy is high from the accepted request until
// the result strobe. rsp_valid is high for exactly one cycle and the receiver
// cannot stall it.
`default_nettype none
module ip_fragment_hole_tracker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_context_slot,
   input  wire logic [15:0] req_frag_offset,
   input  wire logic [15:0] req_frag_len,
   input  wire logic        req_last_fragment,
   input  wire logic [31:0] req_now_time,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [16:0]      rsp_datagram_len,
   output logic [3:0]       rsp_waiting_count,
   output logic [3:0]       rsp_peak_waiting,
   output logic [31:0]      rsp_timed_out_count,
   output logic [31:0]      rsp_dropped_frag_count,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data
);
   import ifht_pkg::*;

   state_type state_ff, state_in;

   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [15:0] off_ff, off_in, len_ff, len_in;
   logic last_ff, last_in;
   logic [31:0] now_ff, now_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] pos_ff, pos_in, sh_ff, sh_in;
   logic [16:0] prev_end_ff, prev_end_in;
   logic [15:0] next_start_ff, next_start_in;
   logic have_next_ff, have_next_in;
   logic fit_left_ff, fit_left_in, fit_right_ff, fit_right_in;
   status_type status_ff, status_in;
   logic [16:0] dlen_ff, dlen_in;

   logic open_ff [NUM_SLOTS];
   logic open_in [NUM_SLOTS];
   logic inval_ff [NUM_SLOTS];
   logic inval_in [NUM_SLOTS];
   logic [31:0] deadline_ff [NUM_SLOTS];
   logic [31:0] deadline_in [NUM_SLOTS];
   logic [16:0] total_ff [NUM_SLOTS];
   logic [16:0] total_in [NUM_SLOTS];
   logic [4:0] holes_ff [NUM_SLOTS];
   logic [4:0] holes_in [NUM_SLOTS];
   logic [CNT_W-1:0] fcnt_ff [NUM_SLOTS];
   logic [CNT_W-1:0] fcnt_in [NUM_SLOTS];

   logic [3:0] open_now_ff, open_now_in, open_peak_ff, open_peak_in;
   logic [31:0] expired_ff, expired_in, discarded_ff, discarded_in;
   logic [31:0] timeout_ff;

   logic mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0] mem_wr_addr, mem_rd_addr;
   ivl_type mem_wr_data, mem_rd_data;

   logic [16:0] frag_end;
   logic [CNT_W-1:0] cnt, sh_m1;
   logic chk_reject, eval_reject, fl, fr, scan_more;
   logic [16:0] rd_end;

   ifht_ivl_ram u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // decode shared by sequencer and datapath
   always_comb begin
      frag_end = {1'b0, off_ff} + {1'b0, len_ff};
      cnt = fcnt_ff[slot_ff];
      sh_m1 = sh_ff - CNT_W'(1);
      rd_end = {1'b0, mem_rd_data.start} + {1'b0, mem_rd_data.length};
      scan_more = mem_rd_data.start <= off_ff;
      chk_reject = (!last_ff && ((len_ff[2:0] & ALIGN_MASK) != 3'd0))
                || (total_ff[slot_ff] != 17'd0 && frag_end > total_ff[slot_ff])
                || (last_ff && total_ff[slot_ff] != 17'd0);
      eval_reject = (prev_end_ff > {1'b0, off_ff})
                 || (have_next_ff && (last_ff || frag_end > {1'b0, next_start_ff}));
      fl = prev_end_ff == {1'b0, off_ff};
      fr = fit_right_ff || (have_next_ff && frag_end == {1'b0, next_start_ff});
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (start) state_in = S_EXPIRE;
         S_EXPIRE:   if (idx_ff == SLOT_W'(NUM_SLOTS - 1)) state_in = S_OPEN;
         S_OPEN:     state_in = S_CHECK;
         S_CHECK: begin
            if (inval_ff[slot_ff] || chk_reject) state_in = S_RESP;
            else state_in = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            if (pos_ff == cnt) state_in = S_EVAL;
            else state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (scan_more) state_in = S_SCAN_RD;
            else state_in = S_EVAL;
         end
         S_EVAL: begin
            if (eval_reject) state_in = S_RESP;
            else if (len_ff != 16'd0) begin
               if (cnt >= CNT_W'(MAX_FRAGS)) state_in = S_RESP;
               else state_in = S_SHIFT_RD;
            end else state_in = S_FINISH;
         end
         S_SHIFT_RD: begin
            if (sh_ff == pos_ff) state_in = S_INSERT;
            else state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: state_in = S_SHIFT_RD;
         S_INSERT:   state_in = S_FINISH;
         S_FINISH:   state_in = S_RESP;
         S_RESP:     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // outputs and memory control
   always_comb begin
      busy = state_ff != S_IDLE;
      rsp_valid = state_ff == S_RESP;
      csr_ready = state_ff == S_IDLE;
      mem_rd_en = 1'b0;
      mem_rd_addr = {slot_ff, pos_ff[IDX_W-1:0]};
      mem_wr_en = 1'b0;
      mem_wr_addr = {slot_ff, pos_ff[IDX_W-1:0]};
      mem_wr_data = '{start: off_ff, length: len_ff};
      unique case (state_ff)
         S_SCAN_RD: mem_rd_en = pos_ff != cnt;
         S_SHIFT_RD: begin
            mem_rd_en = sh_ff != pos_ff;
            mem_rd_addr = {slot_ff, sh_m1[IDX_W-1:0]};
         end
         S_SHIFT_WR: begin
            mem_wr_en = 1'b1;
            mem_wr_addr = {slot_ff, sh_ff[IDX_W-1:0]};
            mem_wr_data = mem_rd_data;
         end
         S_INSERT: mem_wr_en = 1'b1;
         default: begin
         end
      endcase
   end

   assign rsp_status = status_ff;
   assign rsp_datagram_len = dlen_ff;
   assign rsp_waiting_count = open_now_ff;
   assign rsp_peak_waiting = open_peak_ff;
   assign rsp_timed_out_count = expired_ff;
   assign rsp_dropped_frag_count = discarded_ff;

   // datapath
   always_comb begin
      slot_in = slot_ff;
      off_in = off_ff;
      len_in = len_ff;
      last_in = last_ff;
      now_in = now_ff;
      idx_in = idx_ff;
      pos_in = pos_ff;
      sh_in = sh_ff;
      prev_end_in = prev_end_ff;
      next_start_in = next_start_ff;
      have_next_in = have_next_ff;
      fit_left_in = fit_left_ff;
      fit_right_in = fit_right_ff;
      status_in = status_ff;
      dlen_in = dlen_ff;
      open_in = open_ff;
      inval_in = inval_ff;
      deadline_in = deadline_ff;
      total_in = total_ff;
      holes_in = holes_ff;
      fcnt_in = fcnt_ff;
      open_now_in = open_now_ff;
      open_peak_in = open_peak_ff;
      expired_in = expired_ff;
      discarded_in = discarded_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               slot_in = req_context_slot;
               off_in = req_frag_offset;
               len_in = req_frag_len;
               last_in = req_last_fragment;
               now_in = req_now_time;
               idx_in = '0;
               status_in = ST_ACCEPT;
               dlen_in = '0;
            end
         end
         S_EXPIRE: begin
            if (open_ff[idx_ff] && deadline_ff[idx_ff] < now_ff) begin
               expired_in = sat_add32(expired_ff, 32'd1);
               open_in[idx_ff] = 1'b0;
               inval_in[idx_ff] = 1'b0;
               total_in[idx_ff] = '0;
               holes_in[idx_ff] = '0;
               fcnt_in[idx_ff] = '0;
               if (open_now_ff != 4'd0) open_now_in = open_now_ff - 4'd1;
            end
            idx_in = idx_ff + SLOT_W'(1);
         end
         S_OPEN: begin
            if (!open_ff[slot_ff]) begin
               open_in[slot_ff] = 1'b1;
               inval_in[slot_ff] = 1'b0;
               total_in[slot_ff] = '0;
               holes_in[slot_ff] = 5'd1;
               fcnt_in[slot_ff] = '0;
               deadline_in[slot_ff] = sat_add32(now_ff, timeout_ff);
               open_now_in = open_now_ff + 4'd1;
               if (open_now_ff + 4'd1 > open_peak_ff) open_peak_in = open_now_ff + 4'd1;
            end
         end
         S_CHECK: begin
            pos_in = '0;
            prev_end_in = '0;
            have_next_in = 1'b0;
            fit_right_in = last_ff;
            if (inval_ff[slot_ff]) begin
               discarded_in = sat_add32(discarded_ff, 32'd1);
               status_in = ST_INVALID;
            end else if (chk_reject) begin
               inval_in[slot_ff] = 1'b1;
               discarded_in = sat_add32(discarded_ff, 32'(cnt) + 32'd1);
               status_in = ST_REJECT;
            end else if (last_ff) begin
               total_in[slot_ff] = frag_end;
            end
         end
         S_SCAN_CHK: begin
            if (scan_more) begin
               prev_end_in = rd_end;
               pos_in = pos_ff + CNT_W'(1);
            end else begin
               next_start_in = mem_rd_data.start;
               have_next_in = 1'b1;
            end
         end
         S_EVAL: begin
            fit_left_in = fl;
            fit_right_in = fr;
            sh_in = cnt;
            if (eval_reject) begin
               inval_in[slot_ff] = 1'b1;
               discarded_in = sat_add32(discarded_ff, 32'(cnt) + 32'd1);
               status_in = ST_REJECT;
            end else if (len_ff != 16'd0) begin
               if (cnt >= CNT_W'(MAX_FRAGS)) begin
                  inval_in[slot_ff] = 1'b1;
                  discarded_in = sat_add32(discarded_ff, 32'(cnt) + 32'd1);
                  status_in = ST_FULL;
               end
            end else if (last_ff && fl && holes_ff[slot_ff] != 5'd0) begin
               holes_in[slot_ff] = holes_ff[slot_ff] - 5'd1;
            end
         end
         S_SHIFT_WR: sh_in = sh_m1;
         S_INSERT: begin
            fcnt_in[slot_ff] = cnt + CNT_W'(1);
            if (fit_left_ff && fit_right_ff) begin
               if (holes_ff[slot_ff] != 5'd0) holes_in[slot_ff] = holes_ff[slot_ff] - 5'd1;
            end else if (!fit_left_ff && !fit_right_ff) begin
               holes_in[slot_ff] = holes_ff[slot_ff] + 5'd1;
            end
         end
         S_FINISH: begin
            if (holes_ff[slot_ff] == 5'd0) begin
               status_in = ST_COMPLETE;
               dlen_in = total_ff[slot_ff];
               open_in[slot_ff] = 1'b0;
               inval_in[slot_ff] = 1'b0;
               total_in[slot_ff] = '0;
               fcnt_in[slot_ff] = '0;
               if (open_now_ff != 4'd0) open_now_in = open_now_ff - 4'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         status_ff <= ST_ACCEPT;
         dlen_ff <= '0;
         open_now_ff <= '0;
         open_peak_ff <= '0;
         expired_ff <= '0;
         discarded_ff <= '0;
         timeout_ff <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            open_ff[i] <= 1'b0;
            inval_ff[i] <= 1'b0;
            deadline_ff[i] <= '0;
            total_ff[i] <= '0;
            holes_ff[i] <= '0;
            fcnt_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         status_ff <= status_in;
         dlen_ff <= dlen_in;
         open_now_ff <= open_now_in;
         open_peak_ff <= open_peak_in;
         expired_ff <= expired_in;
         discarded_ff <= discarded_in;
         if (csr_valid && csr_ready) timeout_ff <= csr_data;
         open_ff <= open_in;
         inval_ff <= inval_in;
         deadline_ff <= deadline_in;
         total_ff <= total_in;
         holes_ff <= holes_in;
         fcnt_ff <= fcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      off_ff <= off_in;
      len_ff <= len_in;
      last_ff <= last_in;
      now_ff <= now_in;
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      sh_ff <= sh_in;
      prev_end_ff <= prev_end_in;
      next_start_ff <= next_start_in;
      have_next_ff <= have_next_in;
      fit_left_ff <= fit_left_in;
      fit_right_ff <= fit_right_in;
   end
endmodule
`default_nettype wire

/* design/ifht_checker.sv */
// port level checks for the hole tracker and their binding
`default_nettype none
module ifht_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [2:0]  rsp_status,
   input wire logic [16:0] rsp_datagram_len,
   input wire logic [3:0]  rsp_waiting_count,
   input wire logic [3:0]  rsp_peak_waiting
);
   import ifht_pkg::*;

   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("request not taken");
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside request");
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy) else $error("result strobe too long");
   a_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_COMPLETE |-> rsp_datagram_len == 17'd0)
      else $error("length on incomplete result");
   a_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_peak_waiting >= rsp_waiting_count) else $error("peak below count");
endmodule

bind ip_fragment_hole_tracker ifht_checker u_ifht_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_datagram_len (rsp_datagram_len),
   .rsp_waiting_count(rsp_waiting_count),
   .rsp_peak_waiting (rsp_peak_waiting)
);
`default_nettype wire

/* sim/tb_ip_fragment_hole_tracker.sv */
// testbench for the ip fragment hole tracker: directed and random fragments against a predictor
`timescale 1ns / 1ps
module tb_ip_fragment_hole_tracker;
   import ifht_pkg::*;

   typedef struct {
      status_type  status;
      logic [16:0] dlen;
      logic [3:0]  waiting;
      logic [3:0]  peak;
      logic [31:0] expired;
      logic [31:0] dropped;
   } outcome_type;

   typedef struct {
      logic [15:0] off;
      logic [15:0] len;
      logic        last;
   } frag_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_context_slot = '0;
   logic [15:0] req_frag_offset = '0;
   logic [15:0] req_frag_len = '0;
   logic        req_last_fragment = 1'b0;
   logic [31:0] req_now_time = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [16:0] rsp_datagram_len;
   logic [3:0]  rsp_waiting_count;
   logic [3:0]  rsp_peak_waiting;
   logic [31:0] rsp_timed_out_count;
   logic [31:0] rsp_dropped_frag_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;

   ip_fragment_hole_tracker i_dut (.*);

   always #2 clock = ~clock;

   // tracker state mirror
   bit          ctx_open [NUM_SLOTS];
   bit          ctx_bad [NUM_SLOTS];
   int unsigned ctx_deadline [NUM_SLOTS];
   int unsigned ctx_end [NUM_SLOTS];
   int unsigned ctx_holes [NUM_SLOTS];
   int unsigned ctx_count [NUM_SLOTS];
   int unsigned ivl_start [NUM_SLOTS][MAX_FRAGS];
   int unsigned ivl_len [NUM_SLOTS][MAX_FRAGS];
   int unsigned open_cnt, open_max, expired_cnt, dropped_cnt, lifetime;

   outcome_type pending_q[$];
   frag_type    plan_q [NUM_SLOTS][$];
   int          errors = 0;
   logic [31:0] clock_now = 32'd100;

   function automatic int unsigned sat32(int unsigned a, int unsigned b);
      longint unsigned s;
      s = longint'(a) + longint'(b);
      return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : int'(s);
   endfunction

   function automatic void release_ctx(int s);
      ctx_open[s] = 0;
      ctx_bad[s] = 0;
      ctx_end[s] = 0;
      ctx_holes[s] = 0;
      ctx_count[s] = 0;
      if (open_cnt > 0) open_cnt--;
   endfunction

   function automatic status_type place_frag(int s, int unsigned off, int unsigned len, bit last);
      int unsigned fin, cur_end, pos, cnt;
      bit fit_l, fit_r;
      cnt = ctx_count[s];
      fin = off + len;
      cur_end = 0;
      fit_l = 0;
      fit_r = 0;
      pos = 0;
      if (!last && (len & ALIGN_MASK) != 0) return ST_REJECT;
      if (ctx_end[s] != 0 && fin > ctx_end[s]) return ST_REJECT;
      if (last) begin
         if (ctx_end[s] != 0) return ST_REJECT;
         ctx_end[s] = fin;
         fit_r = 1;
      end
      while (pos < cnt && ivl_start[s][pos] <= off) pos++;
      if (pos > 0) cur_end = ivl_start[s][pos-1] + ivl_len[s][pos-1];
      if (cur_end > off) return ST_REJECT;
      if (cur_end == off) fit_l = 1;
      if (pos < cnt) begin
         if (last) return ST_REJECT;
         if (fin > ivl_start[s][pos]) return ST_REJECT;
         if (fin == ivl_start[s][pos]) fit_r = 1;
      end
      if (len != 0) begin
         if (cnt >= MAX_FRAGS) return ST_FULL;
         for (int i = cnt; i > pos; i--) begin
            ivl_start[s][i] = ivl_start[s][i-1];
            ivl_len[s][i] = ivl_len[s][i-1];
         end
         ivl_start[s][pos] = off;
         ivl_len[s][pos] = len;
         ctx_count[s] = cnt + 1;
         if (fit_l && fit_r) begin
            if (ctx_holes[s] > 0) ctx_holes[s]--;
         end else if (!fit_l && !fit_r) begin
            ctx_holes[s]++;
         end
      end else if (last && fit_l) begin
         if (ctx_holes[s] > 0) ctx_holes[s]--;
      end
      return ST_ACCEPT;
   endfunction

   function automatic outcome_type track_frag(int s, int unsigned off, int unsigned len,
                                              bit last, int unsigned now);
      outcome_type r;
      status_type st;
      r.status = ST_ACCEPT;
      r.dlen = '0;
      for (int i = 0; i < NUM_SLOTS; i++)
         if (ctx_open[i] && ctx_deadline[i] < now) begin
            expired_cnt = sat32(expired_cnt, 1);
            release_ctx(i);
         end
      if (!ctx_open[s]) begin
         ctx_open[s] = 1;
         ctx_bad[s] = 0;
         ctx_end[s] = 0;
         ctx_holes[s] = 1;
         ctx_count[s] = 0;
         ctx_deadline[s] = sat32(now, lifetime);
         open_cnt++;
         if (open_cnt > open_max) open_max = open_cnt;
      end
      if (ctx_bad[s]) begin
         dropped_cnt = sat32(dropped_cnt, 1);
         r.status = ST_INVALID;
      end else begin
         st = place_frag(s, off, len, last);
         if (st != ST_ACCEPT) begin
            ctx_bad[s] = 1;
            dropped_cnt = sat32(dropped_cnt, sat32(ctx_count[s], 1));
            r.status = st;
         end else if (ctx_holes[s] == 0) begin
            r.status = ST_COMPLETE;
            r.dlen = ctx_end[s][16:0];
            release_ctx(s);
         end
      end
      r.waiting = open_cnt[3:0];
      r.peak = open_max[3:0];
      r.expired = expired_cnt;
      r.dropped = dropped_cnt;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_valid) begin
         if (pending_q.size() == 0) begin
            report_mismatch("unexpected result, status", 32'(rsp_status), 32'd0);
         end else begin
            e = pending_q.pop_front();
            if (rsp_status !== e.status)
               report_mismatch("status", 32'(rsp_status), 32'(e.status));
            if (rsp_datagram_len !== e.dlen)
               report_mismatch("datagram_len", 32'(rsp_datagram_len), 32'(e.dlen));
            if (rsp_waiting_count !== e.waiting)
               report_mismatch("waiting_count", 32'(rsp_waiting_count), 32'(e.waiting));
            if (rsp_peak_waiting !== e.peak)
               report_mismatch("peak_waiting", 32'(rsp_peak_waiting), 32'(e.peak));
            if (rsp_timed_out_count !== e.expired)
               report_mismatch("timed_out_count", rsp_timed_out_count, e.expired);
            if (rsp_dropped_frag_count !== e.dropped)
               report_mismatch("dropped_frag_count", rsp_dropped_frag_count, e.dropped);
         end
      end
   end

   // one request; start stays high, the caller lowers it on a gap
   task automatic send_frag(int s, logic [15:0] off, logic [15:0] len, bit last);
      req_context_slot <= s[2:0];
      req_frag_offset <= off;
      req_frag_len <= len;
      req_last_fragment <= last;
      req_now_time <= clock_now;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pending_q.push_back(track_frag(s, off, len, last, clock_now));
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_q.size() != 0);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_timeout(logic [31:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      lifetime = v;
   endtask

   task automatic test_complete_and_empty_last();
      write_timeout(32'd1000);
      send_frag(0, 16'd0, 16'd8, 0);
      send_frag(0, 16'd8, 16'd16, 1);
      send_frag(2, 16'd0, 16'd0, 1);
   endtask

   task automatic test_rejections();
      send_frag(1, 16'd0, 16'd5, 0);
      send_frag(1, 16'd8, 16'd8, 0);
      send_frag(3, 16'd16, 16'd8, 1);
      send_frag(3, 16'd0, 16'd32, 0);
      send_frag(4, 16'd8, 16'd8, 1);
      send_frag(4, 16'd0, 16'd8, 1);
      send_frag(5, 16'd0, 16'd16, 0);
      send_frag(5, 16'd8, 16'd8, 0);
      send_frag(6, 16'd16, 16'd8, 0);
      send_frag(6, 16'd0, 16'd8, 1);
   endtask

   task automatic test_field_extremes();
      send_frag(7, 16'hFFFF, 16'hFFFF, 1);
      send_frag(7, 16'd0, 16'hFFF8, 0);
      send_frag(7, 16'hFFF8, 16'd7, 1);
   endtask

   task automatic test_expiry();
      clock_now = clock_now + 32'd5000;
      send_frag(0, 16'd0, 16'd8, 0);
      send_frag(0, 16'd8, 16'd0, 1);
   endtask

   task automatic test_deadline_saturation();
      write_timeout(32'hFFFF_FFFF);
      clock_now = 32'hFFFF_FF00;
      send_frag(2, 16'd0, 16'd8, 0);
      write_timeout(32'h0000_0000);
      clock_now = 32'hFFFF_FFFF;
      send_frag(3, 16'd0, 16'd8, 0);
      send_frag(2, 16'd8, 16'd8, 1);
   endtask

   function automatic void build_plan(int s);
      frag_type f;
      frag_type t;
      int n, j;
      int unsigned pos;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 18) : $urandom_range(1, 5);
      pos = 0;
      for (int i = 0; i < n; i++) begin
         f.off = pos[15:0];
         f.last = (i == n - 1);
         f.len = f.last ? 16'($urandom_range(0, 40)) : 16'(8 * $urandom_range(0, 6));
         pos += f.len;
         plan_q[s].push_back(f);
      end
      for (int i = n - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = plan_q[s][i];
         plan_q[s][i] = plan_q[s][j];
         plan_q[s][j] = t;
      end
   endfunction

   task automatic test_random_traffic(int items);
      frag_type f;
      int s, burst;
      burst = $urandom_range(1, 30);
      for (int k = 0; k < items; k++) begin
         s = $urandom_range(0, NUM_SLOTS - 1);
         if ($urandom_range(0, 99) < 80) begin
            if (plan_q[s].size() == 0) build_plan(s);
            f = plan_q[s].pop_front();
         end else begin
            f.off = 16'($urandom);
            f.len = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom & 32'h0000_00F8);
            f.last = 1'($urandom_range(0, 1));
         end
         clock_now = clock_now + (($urandom_range(0, 49) == 0) ? $urandom_range(0, 3000)
                                                               : $urandom_range(0, 3));
         send_frag(s, f.off, f.len, f.last);
         if (--burst == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clock);
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 30);
         end
      end
   endtask

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      lifetime = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_complete_and_empty_last();
      test_rejections();
      test_field_extremes();
      test_expiry();
      write_timeout(32'd5000);
      test_random_traffic(470);
      write_timeout(32'd0);
      test_random_traffic(470);
      write_timeout(32'd40);
      test_random_traffic(470);
      write_timeout(32'hFFFF_FFFF);
      test_random_traffic(470);
      test_deadline_saturation();
      drain();
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
